FILE: hdl/quoted_or_length_field_splitter_assert.svh
// Assertion macros for the field splitter. Each check is sampled on the rising
// clock and is switched off while reset is asserted.
`ifndef QUOTED_OR_LENGTH_FIELD_SPLITTER_ASSERT_SVH
`define QUOTED_OR_LENGTH_FIELD_SPLITTER_ASSERT_SVH
`ifndef SYNTH
`define QOFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define QOFS_NEVER(lbl, clk, rstn, expr, msg) \
    `QOFS_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define QOFS_ASSERT(lbl, clk, rstn, prop, msg)
`define QOFS_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: hdl/qofs_pkg.sv
package qofs_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int REM_W    = 10;
    localparam int PROD_W   = 14;

    localparam int DEF_MAX_LEN         = 512;
    localparam int DEF_MAX_FIELD_LIMIT = 64;

    localparam logic [CNT_W-1:0]  MAX_FIELDS_RESET = 7'd20;
    localparam logic [BYTE_W-1:0] TICK             = 8'h60;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    // Result queue: three words per byte at most, so four entries keep
    // one byte per cycle flowing while bytes give one word and none stall.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  field_index;
        logic [CNT_W-1:0]  field_count;
        logic              malformed;
        logic              last_of_run;
    } t_result;

    // Words caused by one byte, in output order: payload, field end, done.
    typedef struct packed {
        logic              pay;
        logic              fend;
        logic              done;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic              mal;
    } t_res_set;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room;
    } t_q_status;

endpackage

FILE: hdl/qofs_parse.sv
module qofs_parse
    import qofs_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic [CNT_W-1:0]  i_max_fields,
    output t_res_set          o_set,
    output logic [CNT_W-1:0]  o_fields_done
);

    localparam logic [2:0] M_START   = 3'd0;
    localparam logic [2:0] M_QBODY   = 3'd1;
    localparam logic [2:0] M_DIGITS  = 3'd2;
    localparam logic [2:0] M_DIGSTOP = 3'd3;
    localparam logic [2:0] M_LBODY   = 3'd4;
    localparam logic [2:0] M_SEP     = 3'd5;

    localparam logic [PROD_W-1:0] MaxLenP = PROD_W'(MAX_LEN);

    logic [2:0]        r_mode, n_mode;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_fd, n_fd;

    logic              active;
    logic              digit;
    logic              is_tick;
    logic [3:0]        dval;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  rem_dec;
    logic              pay, fend, mal;
    logic [CNT_W-1:0]  done_count;

    always_comb begin
        active  = r_fd < i_max_fields;
        digit   = i_byte inside {[8'h30:8'h39]};
        is_tick = i_byte == TICK;
        dval    = i_byte[3:0];
        prod    = PROD_W'({r_rem, 3'b000}) + PROD_W'({r_rem, 1'b0}) + PROD_W'(dval);
        rem_dec = (r_rem != '0) ? REM_W'(r_rem - 1'b1) : '0;

        n_mode = r_mode;
        n_rem  = r_rem;
        n_fd   = r_fd;
        pay    = 1'b0;
        fend   = 1'b0;
        mal    = 1'b0;

        if (active) begin
            case (r_mode)
                M_QBODY: begin
                    if (is_tick) begin
                        fend   = 1'b1;
                        n_fd   = CNT_W'(r_fd + 1'b1);
                        n_mode = M_START;
                    end else begin
                        pay = 1'b1;
                    end
                end
                M_DIGITS, M_DIGSTOP: begin
                    if (is_tick) begin
                        if (r_rem == '0) begin
                            fend   = 1'b1;
                            n_fd   = CNT_W'(r_fd + 1'b1);
                            n_mode = M_SEP;
                        end else begin
                            n_mode = M_LBODY;
                        end
                    end else if (r_mode == M_DIGITS && digit) begin
                        n_rem = (prod > MaxLenP) ? MaxLenP[REM_W-1:0] : prod[REM_W-1:0];
                    end else begin
                        n_mode = M_DIGSTOP;
                    end
                end
                M_LBODY: begin
                    pay   = 1'b1;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        fend   = 1'b1;
                        n_fd   = CNT_W'(r_fd + 1'b1);
                        n_mode = M_SEP;
                    end
                end
                M_SEP: begin
                    n_mode = M_START;
                end
                default: begin
                    if (is_tick) begin
                        n_mode = M_QBODY;
                    end else if (digit) begin
                        n_rem  = REM_W'(dval);
                        n_mode = M_DIGITS;
                    end else begin
                        n_rem  = '0;
                        n_mode = M_DIGSTOP;
                    end
                end
            endcase
        end

        // On the last byte a field still open in its body is closed and counted,
        // while one still in its length prefix is dropped and flagged.
        if (i_last && active) begin
            if (n_mode == M_QBODY || n_mode == M_LBODY) begin
                fend = 1'b1;
                n_fd = CNT_W'(n_fd + 1'b1);
            end else if (n_mode == M_DIGITS || n_mode == M_DIGSTOP) begin
                mal = 1'b1;
            end
        end
        done_count = n_fd;
        if (i_last) begin
            n_mode = M_START;
            n_rem  = '0;
            n_fd   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_rem  <= '0;
            r_fd   <= '0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_fd   <= n_fd;
        end
    end

    assign o_set.pay   = pay;
    assign o_set.fend  = fend;
    assign o_set.done  = i_last;
    assign o_set.data  = i_byte;
    assign o_set.idx   = r_fd[IDX_W-1:0];
    assign o_set.count = done_count;
    assign o_set.mal   = mal;

    assign o_fields_done = r_fd;

endmodule

FILE: hdl/qofs_resq.sv
module qofs_resq
    import qofs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_set  i_set,
    input  logic      i_stall,
    output logic      o_valid,
    output t_result   o_result,
    output t_q_status o_status
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;

    t_result            res_p, res_e, res_d;
    logic [Q_PTR_W-1:0] off_e, off_d, n_push;
    logic               pop;

    always_comb begin
        res_p = '{kind: KIND_PAYLOAD, data: i_set.data, field_index: i_set.idx,
                  field_count: '0, malformed: 1'b0,
                  last_of_run: !i_set.fend && !i_set.done};
        res_e = '{kind: KIND_END, data: '0, field_index: i_set.idx,
                  field_count: '0, malformed: 1'b0, last_of_run: !i_set.done};
        res_d = '{kind: KIND_DONE, data: '0, field_index: '0,
                  field_count: i_set.count, malformed: i_set.mal, last_of_run: 1'b1};
        off_e  = Q_PTR_W'(i_set.pay);
        off_d  = Q_PTR_W'(i_set.pay) + Q_PTR_W'(i_set.fend);
        n_push = off_d + Q_PTR_W'(i_set.done);
        pop    = (r_count != '0) && !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_set.pay) begin
                r_mem[r_wr] <= res_p;
            end
            if (i_set.fend) begin
                r_mem[Q_PTR_W'(r_wr + off_e)] <= res_e;
            end
            if (i_set.done) begin
                r_mem[Q_PTR_W'(r_wr + off_d)] <= res_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= Q_PTR_W'(r_wr + n_push);
            end
            if (pop) begin
                r_rd <= Q_PTR_W'(r_rd + 1'b1);
            end
            r_count <= Q_CNT_W'(r_count + (i_push ? Q_CNT_W'(n_push) : '0)
                                - Q_CNT_W'(pop));
        end
    end

    assign o_valid         = r_count != '0;
    assign o_result        = r_mem[r_rd];
    assign o_status.count  = r_count;
    assign o_status.room   = r_count <= Q_CNT_W'(Q_DEPTH - 3);

endmodule

FILE: hdl/quoted_or_length_field_splitter.sv
// Field splitter for a byte stream in which fields are either quoted with
// backticks or carry a decimal length prefix, a backtick and that many bytes.
// Input channel: i_valid / o_stall with i_byte_in and i_is_last; one word is
// one character, and the word with i_is_last high ends the stream.
// Output channel: o_valid / i_stall; each word is one result: a payload byte,
// a field end, or the done word with the field count and malformed flag.
// o_last_of_run marks the final word caused by one input character.
// Configuration: i_cfg_valid / o_cfg_ready writes max_fields; ready is always
// high; the user must make writes only while the block is idle (unchecked).
// The first result of a character is offered after it has passed the input
// register and then been written to the result queue.
// Throughput: one character per cycle while each gives at most one result and
// the receiver does not stall; a character that gives two or three results
// holds the input while the single output port of the result queue drains them.
// When the receiver stalls, the queue fills and o_stall rises on the input.
// Reset clears the parser to field start with no fields counted, empties the
// queue and sets max_fields to 20.
`include "quoted_or_length_field_splitter_assert.svh"

module quoted_or_length_field_splitter
    import qofs_pkg::*;
#(
    parameter int MAX_LEN         = DEF_MAX_LEN,
    parameter int MAX_FIELD_LIMIT = DEF_MAX_FIELD_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_is_last,

    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_data,
    output logic [IDX_W-1:0]  o_field_index,
    output logic [CNT_W-1:0]  o_field_count,
    output logic              o_malformed,
    output logic              o_last_of_run,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam logic [CNT_W-1:0] FieldLimit = CNT_W'(MAX_FIELD_LIMIT);

    // Input register: holds one character until the queue has room for
    // every result it can cause.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic [CNT_W-1:0]  r_max_fields;
    logic [CNT_W-1:0]  n_max_fields;

    logic              load;
    logic              consume;
    t_res_set          set;
    t_result           result;
    t_q_status         q_status;
    logic [CNT_W-1:0]  fields_done;

    assign consume = r_in_valid && q_status.room;
    assign o_stall = r_in_valid && !q_status.room;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_byte_in;
            r_in_last <= i_is_last;
        end
    end

    // A written count of zero becomes one, and counts beyond the limit clamp.
    always_comb begin
        n_max_fields = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_max_fields = CNT_W'(1);
        end else if (i_cfg_data > FieldLimit) begin
            n_max_fields = FieldLimit;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields <= MAX_FIELDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_fields <= n_max_fields;
        end
    end

    qofs_parse #(
        .MAX_LEN (MAX_LEN)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (consume),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_max_fields  (r_max_fields),
        .o_set         (set),
        .o_fields_done (fields_done)
    );

    qofs_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (consume),
        .i_set    (set),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (result),
        .o_status (q_status)
    );

    assign o_kind        = result.kind;
    assign o_data        = result.data;
    assign o_field_index = result.field_index;
    assign o_field_count = result.field_count;
    assign o_malformed   = result.malformed;
    assign o_last_of_run = result.last_of_run;

    // The stored field limit never leaves its legal range.
    `QOFS_NEVER(a_max_fields_range, i_clk, i_rst_n,
        r_max_fields == '0 || r_max_fields > FieldLimit, "max_fields out of range")
    // A character that ends the stream leaves the parser with no fields counted.
    `QOFS_ASSERT(a_last_clears, i_clk, i_rst_n,
        consume && r_in_last |=> fields_done == '0, "field count kept after last byte")
    // With nothing queued and nothing pushed, no result can appear.
    `QOFS_ASSERT(a_no_phantom, i_clk, i_rst_n,
        !o_valid && !consume |=> !o_valid, "result appeared without a character")

endmodule

FILE: tb/sv/quoted_or_length_field_splitter_tb.sv
module quoted_or_length_field_splitter_tb;
    import qofs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Character codes that matter to the length prefix.
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
    // In the directed strings below this character stands for the backtick.
    localparam byte TICK_STAND_IN = "|";
    localparam int unsigned LEN_CAP = DEF_MAX_LEN;
    // Cycles the receiver holds off in one long stretch.
    localparam int LONG_HOLD = 150;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_char_word;

    // Parser position inside the stream, as the block is expected to track it.
    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_QUOTED,
        SCAN_DIGITS,
        SCAN_DIGSTOP,
        SCAN_BODY,
        SCAN_SEP
    } t_scan;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_byte_in = '0;
    logic              i_is_last = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [KIND_W-1:0] o_kind;
    logic [BYTE_W-1:0] o_data;
    logic [IDX_W-1:0]  o_field_index;
    logic [CNT_W-1:0]  o_field_count;
    logic              o_malformed;
    logic              o_last_of_run;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data = '0;

    quoted_or_length_field_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_in     (i_byte_in),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_field_index (o_field_index),
        .o_field_count (o_field_count),
        .o_malformed   (o_malformed),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Characters still to be offered on the input, and the result words that
    // the accepted characters are predicted to produce, oldest first.
    t_char_word stream_chars[$];
    t_result    split_words[$];
    int         bad_words = 0;

    // Splitter state as predicted: parse position, prefix value or payload
    // bytes left, fields closed in this stream, and the max_fields setting.
    t_scan       scan_mode = SCAN_START;
    int unsigned body_left = 0;
    int unsigned fields_seen = 0;
    int unsigned field_cap = MAX_FIELDS_RESET;

    // The newest word of the current character is held back so that the
    // last one can be marked as the end of the run before it is queued.
    t_result held_word;
    logic    have_held = 1'b0;

    function automatic void add_word(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] data,
                                     input int unsigned idx,
                                     input int unsigned count,
                                     input logic mal);
        t_result w;
        w.kind        = kind;
        w.data        = data;
        w.field_index = IDX_W'(idx);
        w.field_count = CNT_W'(count);
        w.malformed   = mal;
        w.last_of_run = 1'b0;
        if (have_held) begin
            split_words.push_back(held_word);
        end
        held_word = w;
        have_held = 1'b1;
    endfunction

    function automatic void end_field();
        add_word(KIND_END, '0, fields_seen, 0, 1'b0);
        fields_seen = (fields_seen + 1) & 7'h7F;
    endfunction

    // Works out the words that one accepted character causes and queues them.
    function automatic void split_char(input logic [BYTE_W-1:0] ch, input logic last);
        logic        active;
        logic        digit;
        logic        mal;
        int unsigned acc;
        have_held = 1'b0;
        active = fields_seen < field_cap;
        digit  = (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
        mal    = 1'b0;
        if (active) begin
            case (scan_mode)
                SCAN_QUOTED: begin
                    if (ch == TICK) begin
                        end_field();
                        scan_mode = SCAN_START;
                    end else begin
                        add_word(KIND_PAYLOAD, ch, fields_seen, 0, 1'b0);
                    end
                end
                SCAN_DIGITS, SCAN_DIGSTOP: begin
                    if (ch == TICK) begin
                        // A zero length closes the field right away, but the
                        // separator byte is still expected after it.
                        if (body_left == 0) begin
                            end_field();
                            scan_mode = SCAN_SEP;
                        end else begin
                            scan_mode = SCAN_BODY;
                        end
                    end else if (scan_mode == SCAN_DIGITS && digit) begin
                        acc = body_left * 10 + (ch - ASCII_ZERO);
                        body_left = (acc > LEN_CAP) ? LEN_CAP : acc;
                    end else begin
                        scan_mode = SCAN_DIGSTOP;
                    end
                end
                SCAN_BODY: begin
                    add_word(KIND_PAYLOAD, ch, fields_seen, 0, 1'b0);
                    if (body_left > 0) begin
                        body_left--;
                    end
                    if (body_left == 0) begin
                        end_field();
                        scan_mode = SCAN_SEP;
                    end
                end
                SCAN_SEP: begin
                    scan_mode = SCAN_START;
                end
                default: begin
                    if (ch == TICK) begin
                        scan_mode = SCAN_QUOTED;
                    end else if (digit) begin
                        body_left = ch - ASCII_ZERO;
                        scan_mode = SCAN_DIGITS;
                    end else begin
                        body_left = 0;
                        scan_mode = SCAN_DIGSTOP;
                    end
                end
            endcase
        end
        if (last) begin
            // A field cut off in its body still counts; one cut off in its
            // length prefix does not, and marks the stream malformed.
            if (active) begin
                if (scan_mode == SCAN_QUOTED || scan_mode == SCAN_BODY) begin
                    end_field();
                end else if (scan_mode == SCAN_DIGITS || scan_mode == SCAN_DIGSTOP) begin
                    mal = 1'b1;
                end
            end
            add_word(KIND_DONE, '0, 0, fields_seen, mal);
            scan_mode   = SCAN_START;
            body_left   = 0;
            fields_seen = 0;
        end
        if (have_held) begin
            held_word.last_of_run = 1'b1;
            split_words.push_back(held_word);
            have_held = 1'b0;
        end
    endfunction

    task automatic flag_word(input string msg);
        if (bad_words < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        bad_words++;
    endtask

    // Sender: bursts of random length with random gaps between them. The
    // prediction runs at the edge where a word is taken, so it always sees
    // characters in the order the block does.
    t_char_word next_char;
    int         burst_left = 1;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                split_char(i_byte_in, i_is_last);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (stream_chars.size() != 0) begin
                    next_char = stream_chars.pop_front();
                    i_valid   <= 1'b1;
                    i_byte_in <= next_char.ch;
                    i_is_last <= next_char.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall rate is picked anew for each random stretch, from
    // none to heavy. A long hold-off starts whenever one is asked for.
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;
    int stall_pct = 0;
    int pattern_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_asked != hold_given) begin
            hold_given = hold_asked;
            hold_left  = LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                pattern_left = $urandom_range(16, 96);
            end else begin
                pattern_left--;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Checker: every word taken is compared field by field with the oldest
    // prediction.
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (split_words.size() == 0) begin
                flag_word($sformatf("word kind %0d with nothing predicted", o_kind));
            end else begin
                want = split_words.pop_front();
                if (o_kind !== want.kind)
                    flag_word($sformatf("kind %0d, predicted %0d", o_kind, want.kind));
                if (o_data !== want.data)
                    flag_word($sformatf("data %0h, predicted %0h", o_data, want.data));
                if (o_field_index !== want.field_index)
                    flag_word($sformatf("field_index %0d, predicted %0d",
                                        o_field_index, want.field_index));
                if (o_field_count !== want.field_count)
                    flag_word($sformatf("field_count %0d, predicted %0d",
                                        o_field_count, want.field_count));
                if (o_malformed !== want.malformed)
                    flag_word($sformatf("malformed %0b, predicted %0b",
                                        o_malformed, want.malformed));
                if (o_last_of_run !== want.last_of_run)
                    flag_word($sformatf("last_of_run %0b, predicted %0b",
                                        o_last_of_run, want.last_of_run));
            end
        end
    end

    task automatic add_char(input logic [BYTE_W-1:0] ch, input logic last);
        t_char_word w;
        w.ch   = ch;
        w.last = last;
        stream_chars.push_back(w);
    endtask

    task automatic add_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            add_char((s[i] == TICK_STAND_IN) ? TICK : s[i],
                     last_at_end && (i == s.len() - 1));
        end
    endtask

    // Waits until the sender has nothing left and every predicted word has
    // come, then lets the pipeline run dry, since a character may cause no
    // word at all and still be in flight.
    task automatic settle();
        while (stream_chars.size() != 0 || i_valid || split_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_max_fields(input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (value == 0) begin
            field_cap = 1;
        end else if (value > DEF_MAX_FIELD_LIMIT) begin
            field_cap = DEF_MAX_FIELD_LIMIT;
        end else begin
            field_cap = value;
        end
    endtask

    task automatic ask_long_hold();
        @(posedge i_clk);
        hold_asked <= hold_asked + 1;
    endtask

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // A byte that is neither a digit nor a backtick.
    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] b;
        do begin
            b = any_byte();
        end while (b == TICK || (b >= ASCII_ZERO && b <= ASCII_NINE));
        return b;
    endfunction

    // Builds one stream: mostly well-formed quoted and length fields with
    // random content, some noise, and now and then a stream cut short.
    task automatic queue_stream(inout int added);
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] b;
        string             digits;
        int                n_fields;
        int                len;
        int                cut;
        n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
        repeat (n_fields) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    seq.push_back(TICK);
                    repeat ($urandom_range(0, 6)) begin
                        do begin
                            b = any_byte();
                        end while (b == TICK);
                        seq.push_back(b);
                    end
                    seq.push_back(TICK);
                end
                4, 5, 6, 7: begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 6);
                    if ($urandom_range(0, 5) == 0) begin
                        seq.push_back(ASCII_ZERO);
                    end
                    digits = $sformatf("%0d", len);
                    for (int i = 0; i < digits.len(); i++) begin
                        seq.push_back(digits[i]);
                    end
                    // Digits after a stray byte must not change the length.
                    if ($urandom_range(0, 7) == 0) begin
                        seq.push_back(junk_byte());
                        seq.push_back(ASCII_ZERO + BYTE_W'($urandom_range(0, 9)));
                    end
                    seq.push_back(TICK);
                    repeat (len) seq.push_back(any_byte());
                    seq.push_back(any_byte());
                end
                8: begin
                    repeat ($urandom_range(1, 3)) seq.push_back(any_byte());
                end
                default: begin
                    // Prefix without any digit: length zero.
                    seq.push_back(junk_byte());
                    if ($urandom_range(0, 1) == 0) begin
                        seq.push_back(junk_byte());
                    end
                    seq.push_back(TICK);
                    seq.push_back(any_byte());
                end
            endcase
        end
        if (seq.size() == 0) begin
            seq.push_back(any_byte());
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut) begin
                void'(seq.pop_back());
            end
        end
        foreach (seq[i]) begin
            add_char(seq[i], i == seq.size() - 1);
        end
        added += seq.size();
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] cap_value, input logic long_hold);
        int added;
        added = 0;
        settle();
        set_max_fields(cap_value);
        while (added < 20) begin
            queue_stream(added);
        end
        if (long_hold) begin
            ask_long_hold();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : stimulus
        int waited;
        wait (i_rst_n);
        @(posedge i_clk);

        // Directed part, max_fields at its reset value of 20. A quoted field
        // with the extreme byte values, a length field whose payload holds
        // a backtick, a zero length with its separator, a sign that is not
        // skipped, digits after a stray byte, and then streams that end
        // inside a length prefix, a quoted field and a length payload.
        add_char(TICK, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(TICK, 1'b0);
        add_text("2|", 1'b0);
        add_char(TICK, 1'b0);
        add_char(8'h7F, 1'b0);
        add_text(",0|;-5|x1x2|Q;9", 1'b1);
        add_text("|z", 1'b1);
        add_text("3|a", 1'b1);

        // Field limit: one field closed and a second one open, then the
        // limit is lowered to the count, so the rest of the stream is
        // ignored and only the done word comes. A write of all ones clamps
        // to the top limit and a write of zero to one.
        settle();
        set_max_fields(7'h7F);
        add_text("|ab||cd", 1'b0);
        settle();
        set_max_fields(7'h00);
        add_text("ef|3|x|", 1'b1);

        // Full field count: more empty quoted fields than the top limit,
        // then a length prefix past the length cap. A 10-bit value that
        // wrapped instead of saturating would close the field after six
        // bytes; a saturated one keeps it open until the stream ends. The
        // receiver holds off for a while so the block backs up its input.
        settle();
        set_max_fields(7'd64);
        repeat (66) add_text("||", 1'b0);
        add_char(any_byte(), 1'b1);
        add_text("1030|", 1'b0);
        repeat (10) add_char(any_byte(), 1'b0);
        add_char(any_byte(), 1'b1);
        ask_long_hold();

        random_phase(7'd3, 1'b0);
        random_phase(7'd64, 1'b1);
        random_phase(7'd1, 1'b0);
        random_phase(MAX_FIELDS_RESET, 1'b0);
        random_phase(CNT_W'($urandom_range(0, 127)), 1'b1);
        random_phase(CNT_W'($urandom_range(1, 64)), 1'b0);

        waited = 0;
        while ((stream_chars.size() != 0 || i_valid || split_words.size() != 0)
               && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (split_words.size() != 0) begin
            flag_word($sformatf("%0d predicted words never came", split_words.size()));
        end
        if (bad_words == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
